// ----- rtl/sktab_pkg.sv -----
// ----------------------------------------------------------------------------
// sktab_pkg
// Shared types and codes for the sorted key/count accumulation table.
// ----------------------------------------------------------------------------
package sktab_pkg;

  // command codes
  localparam logic CMD_ACC  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // one stored table entry
  typedef struct packed {
    logic [15:0] key;
    logic [31:0] total;
  } entry_t;

  // one result word
  typedef struct packed {
    logic [5:0]  position;
    logic [15:0] entry_key;
    logic [31:0] entry_total;
    logic        was_inserted;
    logic [1:0]  status;
    logic [6:0]  entries_used;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_PROBE,
    S_PROBE_WAIT,
    S_SHIFT,
    S_INSERT,
    S_EMIT
  } state_t;

endpackage

// ----- rtl/sktab_if.sv -----
// ----------------------------------------------------------------------------
// sktab_in_if / sktab_out_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface sktab_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] key;
  logic [15:0] amount;
  logic [5:0]  read_index;

  modport source (output valid, command, key, amount, read_index, input ready);
  modport sink   (input valid, command, key, amount, read_index, output ready);
endinterface

interface sktab_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  position;
  logic [15:0] entry_key;
  logic [31:0] entry_total;
  logic        was_inserted;
  logic [1:0]  status;
  logic [6:0]  entries_used;

  modport source (output valid, position, entry_key, entry_total, was_inserted, status,
                  entries_used, input ready);
  modport sink   (input valid, position, entry_key, entry_total, was_inserted, status,
                  entries_used, output ready);
endinterface

// ----- rtl/sorted_key_accumulate_table_core.sv -----
// ----------------------------------------------------------------------------
// sorted_key_accumulate_table_core
// Key/count table kept in ascending key order in one entry memory.
// ----------------------------------------------------------------------------
//
//   channel | dir | payload                                         | handshake
//   --------+-----+-------------------------------------------------+----------
//   in_ch   | in  | command, key, amount, read_index                | valid/ready
//   out_ch  | out | position, entry_key, entry_total, was_inserted, | valid/ready
//           |     | status, entries_used                            |
//
// A read in range waits for the registered memory read; a read out of range
// answers without a memory read. An accumulate first runs a binary search of
// at most ceil(log2(n+1)) steps, n being the entries stored, then adds into
// the found entry (saturating), reports a full table, or shifts the entries
// from the insert position up one place and writes the new entry there.
// The insert shift moves one entry per cycle through the single write port of
// the entry memory; each search step costs a memory read plus a compare.
// Reset (rst_n low, synchronous) empties the table; no clearing pass, since
// only entries below the fill count are ever read.
// One word is in work at a time. A finished result sits in the output
// register, so a stalled out_ch holds only the result hand-off state.
// ----------------------------------------------------------------------------
module sorted_key_accumulate_table_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  sktab_in_if.sink          in_ch,
  sktab_out_if.source       out_ch
);

  localparam int AW = $clog2(TABLE_DEPTH);       // memory address bits
  localparam int CW = $clog2(TABLE_DEPTH + 1);   // fill count bits
  localparam int RW = (CW > 6) ? CW : 6;         // read index compare width

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  sktab_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;       // entries in use
  logic [15:0]       key_r, key_nxt;
  logic [15:0]       amt_r, amt_nxt;
  logic [CW-1:0]     lo_r, lo_nxt;             // search low bound / result position
  logic [CW-1:0]     hi_r, hi_nxt;             // search high bound
  logic [CW-1:0]     mid_r, mid_nxt;           // address under probe
  logic              hit_r, hit_nxt;           // key seen during search
  logic [31:0]       hit_tot_r, hit_tot_nxt;   // its stored count
  logic [CW-1:0]     dst_r, dst_nxt;           // next shift destination
  logic              pend_r, pend_nxt;         // shift read in flight
  logic [AW-1:0]     pend_addr_r, pend_addr_nxt;
  sktab_pkg::res_t   res_r, res_nxt;           // result waiting for output reg
  logic              out_valid_r, out_valid_nxt;
  sktab_pkg::res_t   out_res_r, out_res_nxt;

  // memory port
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  sktab_pkg::entry_t mem_wdata;
  logic [AW-1:0]     mem_raddr;
  sktab_pkg::entry_t mem_rdata;

  // helpers
  logic              in_fire;
  logic [RW-1:0]     ridx_ext;
  logic [RW-1:0]     cnt_ext;
  logic [CW:0]       mid_sum;
  logic [32:0]       acc_sum;
  logic [31:0]       acc_sat;

  sktab_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ch.ready = (state_r == sktab_pkg::S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign ridx_ext = RW'(in_ch.read_index);
  assign cnt_ext  = RW'(count_r);
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};

  // saturating accumulate on a found key
  assign acc_sum = {1'b0, hit_tot_r} + {17'b0, amt_r};
  assign acc_sat = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];

  // --------------------------------------------------------------------------
  // Control: next state, memory port, result
  // Shift reads address d-1 while writing d+1, and probes never overlap a
  // write, so no read/write collision needs forwarding.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    key_nxt       = key_r;
    amt_nxt       = amt_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    hit_nxt       = hit_r;
    hit_tot_nxt   = hit_tot_r;
    dst_nxt       = dst_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;

    mem_we    = 1'b0;
    mem_waddr = pend_addr_r;
    mem_wdata = mem_rdata;
    mem_raddr = '0;

    // output register drains independently of the work in progress
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      sktab_pkg::S_IDLE: begin
        if (in_fire) begin
          key_nxt = in_ch.key;
          amt_nxt = in_ch.amount;
          if (in_ch.command == sktab_pkg::CMD_READ) begin
            if (ridx_ext >= cnt_ext) begin
              res_nxt   = '{6'd0, 16'd0, 32'd0, 1'b0, sktab_pkg::ST_RANGE, 7'(count_r)};
              state_nxt = sktab_pkg::S_EMIT;
            end else begin
              mem_raddr = ridx_ext[AW-1:0];
              lo_nxt    = ridx_ext[CW-1:0];
              state_nxt = sktab_pkg::S_RD_WAIT;
            end
          end else begin
            lo_nxt    = '0;
            hi_nxt    = count_r;
            hit_nxt   = 1'b0;
            state_nxt = sktab_pkg::S_PROBE;
          end
        end
      end

      sktab_pkg::S_RD_WAIT: begin
        res_nxt   = '{6'(lo_r), mem_rdata.key, mem_rdata.total, 1'b0,
                      sktab_pkg::ST_OK, 7'(count_r)};
        state_nxt = sktab_pkg::S_EMIT;
      end

      sktab_pkg::S_PROBE: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_sum[CW:1];
          mem_raddr = mid_sum[AW:1];
          state_nxt = sktab_pkg::S_PROBE_WAIT;
        end else if (hit_r) begin
          // first key not below the search key is the match
          mem_we    = 1'b1;
          mem_waddr = lo_r[AW-1:0];
          mem_wdata = '{key_r, acc_sat};
          res_nxt   = '{6'(lo_r), key_r, acc_sat, 1'b0, sktab_pkg::ST_OK, 7'(count_r)};
          state_nxt = sktab_pkg::S_EMIT;
        end else if (count_r == CW'(TABLE_DEPTH)) begin
          res_nxt   = '{6'd0, 16'd0, 32'd0, 1'b0, sktab_pkg::ST_FULL, 7'(count_r)};
          state_nxt = sktab_pkg::S_EMIT;
        end else begin
          dst_nxt   = count_r;
          pend_nxt  = 1'b0;
          state_nxt = sktab_pkg::S_SHIFT;
        end
      end

      sktab_pkg::S_PROBE_WAIT: begin
        if (mem_rdata.key < key_r) begin
          lo_nxt = mid_r + CW'(1);
        end else begin
          hi_nxt = mid_r;
        end
        if (mem_rdata.key == key_r) begin
          hit_nxt     = 1'b1;
          hit_tot_nxt = mem_rdata.total;
        end
        state_nxt = sktab_pkg::S_PROBE;
      end

      sktab_pkg::S_SHIFT: begin
        // write back the entry read last cycle one place up
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_r;
          mem_wdata = mem_rdata;
        end
        if (dst_r > lo_r) begin
          mem_raddr     = AW'(dst_r - CW'(1));
          pend_nxt      = 1'b1;
          pend_addr_nxt = dst_r[AW-1:0];
          dst_nxt       = dst_r - CW'(1);
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = sktab_pkg::S_INSERT;
        end
      end

      sktab_pkg::S_INSERT: begin
        mem_we    = 1'b1;
        mem_waddr = lo_r[AW-1:0];
        mem_wdata = '{key_r, {16'd0, amt_r}};
        count_nxt = count_r + CW'(1);
        res_nxt   = '{6'(lo_r), key_r, {16'd0, amt_r}, 1'b1, sktab_pkg::ST_OK,
                      7'(count_r + CW'(1))};
        state_nxt = sktab_pkg::S_EMIT;
      end

      sktab_pkg::S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = sktab_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = sktab_pkg::S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // State registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sktab_pkg::S_IDLE;
      count_r     <= '0;
      hit_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      hit_r       <= hit_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    amt_r       <= amt_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    hit_tot_r   <= hit_tot_nxt;
    dst_r       <= dst_nxt;
    pend_addr_r <= pend_addr_nxt;
    res_r       <= res_nxt;
    out_res_r   <= out_res_nxt;
  end

  // --------------------------------------------------------------------------
  // Output channel
  // --------------------------------------------------------------------------
  assign out_ch.valid        = out_valid_r;
  assign out_ch.position     = out_res_r.position;
  assign out_ch.entry_key    = out_res_r.entry_key;
  assign out_ch.entry_total  = out_res_r.entry_total;
  assign out_ch.was_inserted = out_res_r.was_inserted;
  assign out_ch.status       = out_res_r.status;
  assign out_ch.entries_used = out_res_r.entries_used;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sktab_pkg::S_PROBE) |-> (lo_r <= hi_r) && (hi_r <= count_r))
    else $error("search bounds out of order");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sktab_pkg::S_INSERT) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not grow the table by one");

  a_shift_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sktab_pkg::S_SHIFT) |-> (dst_r <= count_r) && (count_r < CW'(TABLE_DEPTH)))
    else $error("shift outside the stored entries");

endmodule

// ----- rtl/sktab_mem.sv -----
// ----------------------------------------------------------------------------
// sktab_mem
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sktab_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  sktab_pkg::entry_t     wdata,
  input  logic [AW-1:0]         raddr,
  output sktab_pkg::entry_t     rdata
);

  sktab_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
